// ----- rtl/rit_pkg.sv -----
// Package for the RAM, I/O and timer block: item types, register-map constants
// and the prescale table. No dependencies; imported by rit_regs and the core.
package rit_pkg;

	// One bus tick as it arrives on the input channel.
	typedef struct packed {
		logic       chip_selected;
		logic       reset_request;
		logic       ram_select;
		logic       is_read;
		logic [6:0] address;
		logic [7:0] write_data;
		logic       pa7_level;
	} req_t;

	// Register-side part of one result.
	typedef struct packed {
		logic       irq;
		logic       valid;
		logic [7:0] data;
	} reg_rsp_t;

	localparam int PRESCALE_W = 11;

	// Register map with address bit 2 clear: low two address bits.
	localparam logic [1:0] REG_DIR_A = 2'b01;
	localparam logic [1:0] REG_DIR_B = 2'b11;

	// Address bits in the timer and interrupt area.
	localparam int TMR_AREA_BIT  = 2;
	localparam int TMR_IRQEN_BIT = 3;
	localparam int TMR_WRITE_BIT = 4;
	localparam int PA7_EN_BIT    = 1;
	localparam int FLAG_RD_BIT   = 0;

	// Flag register bit positions.
	localparam int FLAG_PA7   = 0;
	localparam int FLAG_TIMER = 1;

	// Prescale reload chosen by the low two address bits on a timer write.
	function automatic logic [PRESCALE_W-1:0] prescale_reload(logic [1:0] sel);
		logic [PRESCALE_W-1:0] r;
		unique case (sel)
			2'b00: r = PRESCALE_W'(1);
			2'b01: r = PRESCALE_W'(8);
			2'b10: r = PRESCALE_W'(64);
			2'b11: r = PRESCALE_W'(1024);
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/rit_in_if.sv -----
// Input channel of the RAM, I/O and timer block: valid/ready plus one bus tick.
// Stands alone; used by the top level.
interface rit_in_if;
	logic       valid;
	logic       ready;
	logic       chip_selected;
	logic       reset_request;
	logic       ram_select;
	logic       is_read;
	logic [6:0] address;
	logic [7:0] write_data;
	logic       pa7_level;

	modport source (
		output valid, chip_selected, reset_request, ram_select, is_read,
			address, write_data, pa7_level,
		input  ready
	);
	modport sink (
		input  valid, chip_selected, reset_request, ram_select, is_read,
			address, write_data, pa7_level,
		output ready
	);
endinterface

// ----- rtl/rit_out_if.sv -----
// Output channel of the RAM, I/O and timer block: valid/ready plus one result.
// Stands alone; used by the top level.
interface rit_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       read_valid;
	logic       irq_n;

	modport source (
		output valid, read_data, read_valid, irq_n,
		input  ready
	);
	modport sink (
		input  valid, read_data, read_valid, irq_n,
		output ready
	);
endinterface

// ----- rtl/rit_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module rit_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port, and read port with old data on a same-edge collision.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// ----- rtl/rit_regs.sv -----
// Direction registers, interrupt flags and enables, interval timer and prescaler.
// Depends on rit_pkg; the top level steps it once per retired item.
module rit_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  rit_pkg::req_t     item,
	output rit_pkg::reg_rsp_t rsp
);
	import rit_pkg::*;

	logic [7:0]            dir_a_q, dir_b_q, timer_q;
	logic [1:0]            flags_q;
	logic [PRESCALE_W-1:0] pcount_q, preload_q;
	logic                  pa7_en_q, tmr_en_q;

	logic [7:0]            dir_a_d, dir_b_d, timer_d;
	logic [1:0]            flags_d;
	logic [PRESCALE_W-1:0] pcount_d, preload_d, pcount_dec;
	logic                  pa7_en_d, tmr_en_d;
	logic                  active, fire_pa7, fire_tmr;

	assign active = item.chip_selected && !item.reset_request;

	// Next state and register-side result for the item at hand.
	always_comb begin
		dir_a_d   = dir_a_q;
		dir_b_d   = dir_b_q;
		timer_d   = timer_q;
		flags_d   = flags_q;
		pcount_d  = pcount_q;
		preload_d = preload_q;
		pa7_en_d  = pa7_en_q;
		tmr_en_d  = tmr_en_q;
		rsp       = '0;
		fire_pa7  = 1'b0;
		fire_tmr  = 1'b0;
		pcount_dec = pcount_q - PRESCALE_W'(1);

		if (item.chip_selected && item.reset_request) begin
			dir_a_d  = '0;
			dir_b_d  = '0;
			pa7_en_d = 1'b0;
			tmr_en_d = 1'b0;
		end else if (active) begin
			// Prescaler and timer advance first.
			pcount_d = pcount_dec;
			if (pcount_dec == '0) begin
				pcount_d = preload_q;
				timer_d  = timer_q - 8'd1;
			end

			// Level interrupts latch into the flags.
			fire_pa7 = pa7_en_q && item.pa7_level;
			fire_tmr = tmr_en_q && (timer_d == '0);
			if (fire_pa7) begin
				flags_d[FLAG_PA7] = 1'b1;
			end
			if (fire_tmr) begin
				flags_d[FLAG_TIMER] = 1'b1;
			end
			rsp.irq = fire_pa7 || fire_tmr;

			// Bus access to the register area.
			if (!item.ram_select) begin
				if (!item.address[TMR_AREA_BIT]) begin
					unique case (item.address[1:0])
						REG_DIR_A: begin
							if (item.is_read) begin
								rsp.data  = dir_a_q;
								rsp.valid = 1'b1;
							end else begin
								dir_a_d = item.write_data;
							end
						end
						REG_DIR_B: begin
							if (item.is_read) begin
								rsp.data  = dir_b_q;
								rsp.valid = 1'b1;
							end else begin
								dir_b_d = item.write_data;
							end
						end
						default: begin
						end
					endcase
				end else begin
					if (item.is_read && !item.address[TMR_WRITE_BIT]) begin
						pa7_en_d = !item.address[PA7_EN_BIT];
					end
					if (item.is_read && item.address[FLAG_RD_BIT]) begin
						rsp.data  = {flags_d, 6'b0};
						rsp.valid = 1'b1;
						flags_d[FLAG_PA7] = 1'b0;
					end
					tmr_en_d = item.address[TMR_IRQEN_BIT];
					if (!item.is_read && item.address[TMR_WRITE_BIT]) begin
						timer_d   = item.write_data;
						preload_d = prescale_reload(item.address[1:0]);
						pcount_d  = preload_d;
						flags_d[FLAG_TIMER] = 1'b0;
					end
				end
			end
		end
	end

	// State registers, updated once per retired item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_a_q   <= '0;
			dir_b_q   <= '0;
			timer_q   <= '0;
			flags_q   <= '0;
			pcount_q  <= PRESCALE_W'(1);
			preload_q <= PRESCALE_W'(1);
			pa7_en_q  <= 1'b0;
			tmr_en_q  <= 1'b0;
		end else if (step) begin
			dir_a_q   <= dir_a_d;
			dir_b_q   <= dir_b_d;
			timer_q   <= timer_d;
			flags_q   <= flags_d;
			pcount_q  <= pcount_d;
			preload_q <= preload_d;
			pa7_en_q  <= pa7_en_d;
			tmr_en_q  <= tmr_en_d;
		end
	end
endmodule

// ----- rtl/riot_ram_io_timer_core.sv -----
// RAM, I/O and timer block, one bus tick per item.
// A result is offered from the output register once its item has passed the input stage.
// Throughput: one item per cycle while results are taken, set by the input stage feeding the output register.
// The RAM read is issued at acceptance and a write retiring on that edge is forwarded.
// Reset clears the pipeline, the timer and register state, and the RAM valid bits,
// so never-written RAM locations read as zero.
module riot_ram_io_timer_core #(
	parameter int RAM_DEPTH = 128
) (
	input  logic      clk,
	input  logic      arst_n,
	rit_in_if.sink    req,
	rit_out_if.source rsp
);
	import rit_pkg::*;

	localparam int RAM_AW    = $clog2(RAM_DEPTH);
	localparam int MOD_STEPS = 127 / RAM_DEPTH;
	localparam int MOD_BITS  = $clog2(MOD_STEPS + 1);

	// Address wraps modulo the RAM depth by compare and subtract of scaled depths.
	function automatic logic [RAM_AW-1:0] ram_index(logic [6:0] a);
		logic [8:0] t;
		t = {2'b00, a};
		for (int k = MOD_BITS - 1; k >= 0; k--) begin
			if (t >= 9'(RAM_DEPTH << k)) begin
				t = t - 9'(RAM_DEPTH << k);
			end
		end
		return t[RAM_AW-1:0];
	endfunction

	req_t              in_item, item_s1;
	logic              s1_vld, s1_adv, accept;
	logic [RAM_AW-1:0] in_idx, idx_s1;
	logic              byp_s1, ramvld_s1;
	logic [7:0]        byp_data_s1, ram_rd, ram_data;
	logic [RAM_DEPTH-1:0] ram_vld_q;
	logic              ram_we, byp_hit;
	logic              out_vld_q, read_valid_q, irq_n_q;
	logic [7:0]        read_data_q;
	reg_rsp_t          reg_rsp;
	logic              ram_rd_hit;

	assign in_item = '{
		chip_selected: req.chip_selected,
		reset_request: req.reset_request,
		ram_select:    req.ram_select,
		is_read:       req.is_read,
		address:       req.address,
		write_data:    req.write_data,
		pa7_level:     req.pa7_level
	};

	// Handshake: the input stage moves on whenever the output register is empty or its result is being taken.
	assign s1_adv    = s1_vld && (!out_vld_q || rsp.ready);
	assign req.ready = !s1_vld || s1_adv;
	assign accept    = req.valid && req.ready;
	assign in_idx    = ram_index(req.address);

	// RAM write from the retiring item, and forwarding into the incoming read.
	assign ram_we = s1_adv && item_s1.chip_selected && !item_s1.reset_request
		&& item_s1.ram_select && !item_s1.is_read;
	assign byp_hit = ram_we && (idx_s1 == in_idx);

	rit_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (idx_s1),
		.wr_data (item_s1.write_data),
		.rd_en   (accept),
		.rd_addr (in_idx),
		.rd_data (ram_rd)
	);

	// RAM valid bits, so unwritten locations read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_vld_q <= '0;
		end else if (ram_we) begin
			ram_vld_q[idx_s1] <= 1'b1;
		end
	end

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld <= 1'b0;
		end else if (accept) begin
			s1_vld <= 1'b1;
		end else if (s1_adv) begin
			s1_vld <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1     <= in_item;
			idx_s1      <= in_idx;
			byp_s1      <= byp_hit;
			byp_data_s1 <= item_s1.write_data;
			ramvld_s1   <= ram_vld_q[in_idx] || byp_hit;
		end
	end

	rit_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (s1_adv),
		.item   (item_s1),
		.rsp    (reg_rsp)
	);

	// Result selection between the RAM read and the register side.
	assign ram_data   = byp_s1 ? byp_data_s1 : (ramvld_s1 ? ram_rd : 8'd0);
	assign ram_rd_hit = item_s1.chip_selected && !item_s1.reset_request
		&& item_s1.ram_select && item_s1.is_read;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_adv) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			read_data_q  <= ram_rd_hit ? ram_data : reg_rsp.data;
			read_valid_q <= ram_rd_hit || reg_rsp.valid;
			irq_n_q      <= !reg_rsp.irq;
		end
	end

	assign rsp.valid      = out_vld_q;
	assign rsp.read_data  = read_data_q;
	assign rsp.read_valid = read_valid_q;
	assign rsp.irq_n      = irq_n_q;

	// An unselected tick yields an empty result with the interrupt pin high.
	a_unselected_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && !item_s1.chip_selected |=> irq_n_q && !read_valid_q
			&& read_data_q == 8'd0)
		else $error("unselected tick produced data or an interrupt");

	// The input stage never takes an item while it is full and blocked.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		s1_vld && out_vld_q && !rsp.ready |-> !req.ready)
		else $error("input accepted while the pipeline is stalled");

	// A RAM write marks its location valid.
	a_ram_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> ram_vld_q[$past(idx_s1)])
		else $error("RAM valid bit not set after a write");

	// An accepted item is held in the input stage on the next cycle.
	a_accept_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_vld)
		else $error("accepted item lost before the input stage");
endmodule
